// File: sv/bwt_pkg.sv
// bwt_pkg: shared constants and types for the block transform
// no dependencies
package bwt_pkg;
    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W = 8;

    typedef struct packed {
        logic load;       // store incoming symbol
        logic init_sort;  // reset sort counters
        logic cmp_step;   // one sort step
        logic emit;       // issue one result
    } t_cmd;

    typedef struct packed {
        logic sort_done;
        logic emit_last;
        logic out_final;  // final result is on the outputs
    } t_status;
endpackage

// File: sv/bwt_datapath.sv
// bwt_datapath: symbol store, order list and insertion sort datapath
// depends on bwt_pkg
module bwt_datapath #(
    parameter int MAX_LEN = bwt_pkg::MAX_LEN_DEF,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int CW = $clog2(MAX_LEN + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bwt_pkg::t_cmd             i_cmd,
    input  logic [bwt_pkg::SYM_W-1:0] i_symbol,
    output bwt_pkg::t_status          o_status,
    output logic                      o_valid,
    output logic [bwt_pkg::SYM_W-1:0] o_sym,
    output logic                      o_final,
    output logic                      o_ovf
);
    // sort phases
    localparam logic [1:0] PH_OPEN  = 2'd0;  // begin inserting the next key
    localparam logic [1:0] PH_ADDR  = 2'd1;  // set up one rotation compare
    localparam logic [1:0] PH_CMP   = 2'd2;  // one byte compare per cycle
    localparam logic [1:0] PH_PLACE = 2'd3;  // key sinks to the bottom entry

    logic [bwt_pkg::SYM_W-1:0] r_buf [MAX_LEN];
    logic [AW-1:0]             r_ord [MAX_LEN];
    logic [CW-1:0] r_fill, n_fill;
    logic          r_ovf;
    // sort state: i outer index, j insert position, k compare offset
    logic [1:0]    r_ph;
    logic [CW-1:0] r_i, r_j, r_k;
    logic [AW-1:0] r_key, r_prev, r_ia, r_ib;
    logic [CW-1:0] r_e;
    // registered read data
    logic [bwt_pkg::SYM_W-1:0] r_ca, r_cb;
    logic [AW-1:0]             r_ordq;
    // emit pipeline
    logic          r_v1, r_f1, r_v2, r_f2;

    logic [AW-1:0] buf_ra, buf_rb, ord_ra, ord_wa, ord_wd;
    logic          ord_we;
    logic [AW-1:0] n1, last;
    logic          key_below, key_stays;

    // next start position within the block, wrapping at the end
    function automatic logic [AW-1:0] step_wrap(input logic [AW-1:0] a,
                                                input logic [AW-1:0] top);
        return (a == top) ? '0 : a + AW'(1);
    endfunction

    assign n1 = AW'(r_fill - CW'(1));
    assign last = (r_ordq == '0) ? n1 : r_ordq - AW'(1);
    assign key_below = (r_ca < r_cb);
    assign key_stays = (r_ca > r_cb) || (r_k + CW'(1) == r_fill);

    assign o_status.sort_done = (r_ph == PH_OPEN) && (r_i >= r_fill);
    assign o_status.emit_last = (r_e + CW'(1) == r_fill);
    assign o_status.out_final = r_v2 && r_f2;
    assign o_valid = r_v2;
    assign o_sym = r_ca;
    assign o_final = r_f2;
    assign o_ovf = r_ovf;

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.load && r_fill != CW'(MAX_LEN)) n_fill = r_fill + CW'(1);
    end

    // read addresses of the symbol store
    always_comb begin
        buf_ra = last;
        buf_rb = r_ib;
        if (r_ph == PH_ADDR) begin
            buf_ra = r_key;
            buf_rb = r_ordq;
        end else if (r_ph == PH_CMP) begin
            buf_ra = r_ia;
        end
    end

    // read and write port of the order list
    always_comb begin
        if (i_cmd.emit) ord_ra = r_e[AW-1:0];
        else if (r_ph == PH_OPEN) ord_ra = AW'(r_i - CW'(1));
        else ord_ra = AW'(r_j - CW'(2));
        ord_we = 1'b0;
        ord_wa = r_j[AW-1:0];
        ord_wd = r_key;
        if (i_cmd.init_sort) begin
            ord_we = 1'b1;
            ord_wa = '0;
            ord_wd = '0;
        end else if (i_cmd.cmp_step) begin
            if (r_ph == PH_CMP) begin
                ord_we = key_below || key_stays;
                if (key_below) ord_wd = r_prev;
            end else if (r_ph == PH_PLACE) begin
                ord_we = 1'b1;
            end
        end
    end

    // control-state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf <= 1'b0;
            r_ph <= PH_OPEN;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            r_e <= '0;
            r_key <= '0;
            r_prev <= '0;
            r_ia <= '0;
            r_ib <= '0;
            r_v1 <= 1'b0;
            r_f1 <= 1'b0;
            r_v2 <= 1'b0;
            r_f2 <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_fill <= n_fill;
                if (r_fill == CW'(MAX_LEN)) r_ovf <= 1'b1;
            end
            // order read, then symbol read, then output
            r_v1 <= i_cmd.emit;
            r_f1 <= i_cmd.emit && o_status.emit_last;
            r_v2 <= r_v1;
            r_f2 <= r_f1;
            if (i_cmd.emit) r_e <= r_e + CW'(1);
            if (o_status.out_final) begin
                r_fill <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cmd.init_sort) begin
                r_ph <= PH_OPEN;
                r_i <= CW'(1);
                r_e <= '0;
            end else if (i_cmd.cmp_step) begin
                unique case (r_ph)
                    PH_OPEN: begin
                        // key i starts at j = i
                        r_key <= r_i[AW-1:0];
                        r_j <= r_i;
                        r_ph <= PH_ADDR;
                    end
                    PH_ADDR: begin
                        r_prev <= r_ordq;
                        r_ia <= step_wrap(r_key, n1);
                        r_ib <= step_wrap(r_ordq, n1);
                        r_k <= '0;
                        r_ph <= PH_CMP;
                    end
                    PH_CMP: begin
                        if (key_below) begin
                            // key below: entry moved up, try the next one
                            r_j <= r_j - CW'(1);
                            r_ph <= (r_j == CW'(1)) ? PH_PLACE : PH_ADDR;
                        end else if (key_stays) begin
                            // in place, next key
                            r_i <= r_i + CW'(1);
                            r_ph <= PH_OPEN;
                        end else begin
                            r_ia <= step_wrap(r_ia, n1);
                            r_ib <= step_wrap(r_ib, n1);
                            r_k <= r_k + CW'(1);
                        end
                    end
                    PH_PLACE: begin
                        r_i <= r_i + CW'(1);
                        r_ph <= PH_OPEN;
                    end
                    default: r_ph <= PH_OPEN;
                endcase
            end
        end
    end

    // symbol store and order list
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_fill != CW'(MAX_LEN))
            r_buf[r_fill[AW-1:0]] <= i_symbol;
        if (ord_we)
            r_ord[ord_wa] <= ord_wd;
        r_ordq <= r_ord[ord_ra];
        r_ca <= r_buf[buf_ra];
        r_cb <= r_buf[buf_rb];
    end
endmodule

// File: sv/bwt_ctrl.sv
// bwt_ctrl: controller state machine for load, sort and emit phases
// depends on bwt_pkg
module bwt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_block_end,
    input  bwt_pkg::t_status i_status,
    output bwt_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_SORT  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    logic [2:0] r_state, n_state;
    logic       acc;

    assign acc = i_start && (r_state == S_LOAD);
    assign o_busy = (r_state != S_LOAD);

    // commands and next state
    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = acc;
                if (acc && i_block_end) n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_sort = 1'b1;
                n_state = S_SORT;
            end
            S_SORT: begin
                o_cmd.cmp_step = 1'b1;
                if (i_status.sort_done) begin
                    o_cmd.cmp_step = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_status.out_final) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else r_state <= n_state;
    end
endmodule

// File: sv/bwt_block_transform.sv
// bwt_block_transform: top level of the block transform
// depends on bwt_pkg, bwt_ctrl, bwt_datapath
//
// usage: drive i_symbol and i_block_end with start; a transfer happens at
// an edge where start is high and busy is low. while loading, symbols are
// taken one per cycle; the transfer with i_block_end high closes the block.
// symbols beyond MAX_LEN are dropped and the block's results carry o_overflow.
// after the closing transfer busy rises: a setup state, then an insertion
// sort of the rotations. each key is first opened; each rotation it passes
// gets a setup step and then a byte-by-byte compare, and a key that sinks to
// the bottom takes one more placing step; a final step ends the sort, whose
// length depends on the data. each result is read from the order list and
// then from the symbol store; one result per stored symbol follows on
// consecutive cycles, each marked by o_strobe for one cycle; the
// last carries o_final_result and busy falls on the cycle after it. one block
// is handled at a time. the receiver cannot stall.
// reset (synchronous, active low) empties the store and returns to loading.
module bwt_block_transform #(
    parameter int MAX_LEN = bwt_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_symbol,
    input  logic       i_block_end,
    output logic       o_strobe,
    output logic [7:0] o_last_column_symbol,
    output logic       o_final_result,
    output logic       o_overflow
);
    bwt_pkg::t_cmd    cmd;
    bwt_pkg::t_status status;

    bwt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_block_end(i_block_end), .i_status(status), .o_cmd(cmd),
        .o_busy(busy)
    );

    bwt_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_symbol(i_symbol),
        .o_status(status), .o_valid(o_strobe),
        .o_sym(o_last_column_symbol), .o_final(o_final_result),
        .o_ovf(o_overflow)
    );
endmodule

// File: sv/bwt_checker.sv
// bwt_port_checker: port-level checks of the block transform
// depends on bwt_block_transform (bound to it)
module bwt_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_block_end,
    input logic o_strobe,
    input logic o_final_result
);
    // no result while taking symbols
    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_strobe) else $error("strobe while idle");
    // closing transfer makes the block busy
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_block_end) |=> busy) else $error("not busy");
    // final result releases the block
    a_final_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_result) |=> !busy) else $error("still busy");
    // results run back to back until the final one
    a_emit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_final_result) |=> o_strobe) else $error("gap");
endmodule

bind bwt_block_transform bwt_port_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_block_end(i_block_end), .o_strobe(o_strobe),
    .o_final_result(o_final_result)
);

// File: tb/sv/bwt_checker.sv
// bwt_checker: watches the symbol and result channels of the block transform
// predicts the last column of each closed block and compares every result
// depends on bwt_pkg for the block size
`timescale 1ns / 100ps

module bwt_checker #(
    parameter int MAX_LEN = bwt_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [7:0] i_symbol,
    input  logic       i_block_end,
    input  logic       o_strobe,
    input  logic [7:0] o_last_column_symbol,
    input  logic       o_final_result,
    input  logic       o_overflow,
    output int         o_fail_count,
    output int         o_pending
);
    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       ovf;
    } t_bwt_result;

    logic [7:0]  store_q [MAX_LEN];
    int          stored_n;
    logic        dropped;
    t_bwt_result column_q[$];
    int          predicted_cnt;
    int          compared_cnt;

    // true when the rotation starting at a sorts strictly ahead of the one at b
    function automatic bit rotation_ahead(int a, int b, int n);
        int ia;
        int ib;
        ia = a;
        ib = b;
        for (int k = 0; k < n; k++) begin
            if (store_q[ia] != store_q[ib])
                return store_q[ia] < store_q[ib];
            ia = (ia + 1 < n) ? ia + 1 : 0;
            ib = (ib + 1 < n) ? ib + 1 : 0;
        end
        return 1'b0;
    endfunction

    // sort the rotations of the stored block and queue the last column
    task automatic predict_last_column();
        int order[MAX_LEN];
        int key;
        int j;
        int first;
        t_bwt_result r;
        for (int i = 0; i < stored_n; i++)
            order[i] = i;
        for (int i = 1; i < stored_n; i++) begin
            key = order[i];
            j = i;
            while (j > 0 && rotation_ahead(key, order[j - 1], stored_n)) begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = key;
        end
        for (int k = 0; k < stored_n; k++) begin
            first = order[k];
            r.sym = store_q[(first == 0) ? stored_n - 1 : first - 1];
            r.last = (k + 1 == stored_n);
            r.ovf = dropped;
            column_q = {column_q, r};
            predicted_cnt++;
        end
    endtask

    // report a mismatch, first ten in full
    task automatic note_mismatch(string what, int exp_v, int act_v);
        if (o_fail_count < 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d",
                     $realtime, what, exp_v, act_v);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        stored_n = 0;
        dropped = 1'b0;
        predicted_cnt = 0;
        compared_cnt = 0;
    end

    assign o_pending = predicted_cnt - compared_cnt;

    // input transfers: store symbols, predict on block end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_n = 0;
            dropped = 1'b0;
        end else if (start && !busy) begin
            if (stored_n < MAX_LEN) begin
                store_q[stored_n] = i_symbol;
                stored_n++;
            end else begin
                dropped = 1'b1;
            end
            if (i_block_end) begin
                predict_last_column();
                stored_n = 0;
                dropped = 1'b0;
            end
        end
    end

    // result transfers: compare with the oldest expectation
    always @(posedge i_clk) begin
        t_bwt_result e;
        if (i_rst_n && o_strobe) begin
            if (column_q.size() == 0) begin
                note_mismatch("unexpected result", 0, o_last_column_symbol);
            end else begin
                e = column_q.pop_front();
                compared_cnt++;
                if (o_last_column_symbol !== e.sym)
                    note_mismatch("last_column_symbol", e.sym, o_last_column_symbol);
                if (o_final_result !== e.last)
                    note_mismatch("final_result", e.last, o_final_result);
                if (o_overflow !== e.ovf)
                    note_mismatch("overflow", e.ovf, o_overflow);
            end
        end
    end
endmodule

// File: tb/sv/testbench.sv
// testbench: stimulus and verdict for the block transform
// depends on bwt_pkg, bwt_block_transform and bwt_checker
`timescale 1ns / 100ps

module testbench;
    localparam int BLOCK_CAP = bwt_pkg::MAX_LEN_DEF;
    localparam int ITEM_TARGET = 450;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_symbol;
    logic       i_block_end;
    logic       o_strobe;
    logic [7:0] o_last_column_symbol;
    logic       o_final_result;
    logic       o_overflow;
    int         fail_count;
    int         pending;
    int         items_sent;
    bit         gaps_on;

    bwt_block_transform #(.MAX_LEN(BLOCK_CAP)) uut (.*);

    bwt_checker #(.MAX_LEN(BLOCK_CAP)) u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_symbol, .i_block_end,
        .o_strobe, .o_last_column_symbol, .o_final_result, .o_overflow,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // one symbol transfer, with an occasional idle burst before it
    task automatic send_symbol(logic [7:0] sym, logic last);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_symbol <= sym;
        i_block_end <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // a block of n symbols; alphabet limits the symbol range for repeats
    task automatic send_block(int n, int alphabet);
        for (int i = 0; i < n; i++)
            send_symbol(8'($urandom_range(0, alphabet - 1)), i == n - 1);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send_symbol(s[i], i == s.len() - 1);
    endtask

    initial begin
        int pick;
        start = 1'b0;
        i_symbol = '0;
        i_block_end = 1'b0;
        i_rst_n = 1'b0;
        items_sent = 0;
        gaps_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single symbol extremes, classic word, periodic block, mixed extremes
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hff, 1'b1);
        send_string("banana");
        send_string("abab");
        send_symbol(8'hff, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h01, 1'b1);

        // hold off until every result of the directed part has come
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // full block of one repeated symbol, then one that overflows
        for (int i = 0; i < BLOCK_CAP; i++)
            send_symbol(8'h5a, i == BLOCK_CAP - 1);
        send_block(BLOCK_CAP + 3, 256);

        // random blocks, mostly short, some small-alphabet, a few full size or overflowing
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - 60)
                gaps_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_block(BLOCK_CAP, 256);
            else if (pick < 5)
                send_block(BLOCK_CAP + $urandom_range(1, 6), 4);
            else if (pick < 35)
                send_block($urandom_range(1, 12), $urandom_range(1, 3));
            else
                send_block($urandom_range(1, 12), 256);
        end
        start <= 1'b0;

        // drain, then a short quiet spell
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
